FILE: sv/htd_pkg.sv
package htd_pkg;

   localparam int IDX_W              = 10;
   localparam int SYM_W              = 9;
   localparam int BYTE_W             = 8;
   localparam int OP_W               = 2;
   localparam int REQ_DATA_W         = 48;
   localparam int RSP_DATA_W         = 8;
   localparam int NODE_COUNT_DEFAULT = 1024;

   // reciprocal scaling for index wrap: exact for 10-bit values and divisors from 2 to 2047
   localparam int WRAP_SHIFT = 2 * IDX_W + 1;
   localparam int PROD_W     = IDX_W + WRAP_SHIFT;

   localparam logic [SYM_W-1:0] EOF_SYMBOL = 9'd256;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 2'd0,
      OP_BIT     = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_CUR,
      ST_NEXT
   } state_type;

endpackage

FILE: sv/huffman_tree_decoder_top.sv
// Huffman code-tree walk decoder.
// req channel: one item per handshake. req_tuser carries the op (node write, decode one
//   bit, restart). Node writes fill the code-tree table; bit items walk it from the root.
// rsp channel: one item per decoded symbol, rsp_tdata the byte, rsp_tlast set (byte zero)
//   for the pseudo end-of-file symbol; later bits are dropped until a restart item.
// csr channel: writes the root node index; it and req are blocked in the cycle after.
// Steps per item: restart and ignored items pass only through the idle state, a node
//   write through WRITE, a bit item through CUR when the current node is a leaf and
//   through CUR and NEXT when its child is read as well. The steps are set by the single
//   read port of the node table, whose registered read lies in the chain of dependent
//   reads of one tree step.
// Result register: a result waits in rsp while the next items are accepted; a bit item
//   that must emit while the previous result is still stalled holds until it is taken.
// Reset (synchronous): walk at entry 0, root 0, end mark cleared, rsp empty. Table
//   contents are not cleared and must be written before they are walked.
module huffman_tree_decoder_top #(
   parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // code_bit[0], node_index[10:1], node_is_leaf[11], node_symbol[20:12],
   // zero_child[30:21], one_child[40:31], zero pad
   input  logic [htd_pkg::REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [htd_pkg::OP_W-1:0]       req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // byte_out[7:0]
   output logic [htd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [htd_pkg::IDX_W-1:0]      csr_wdata
);

   localparam int AW      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int ENTRY_W = 1 + htd_pkg::SYM_W + 2 * AW;
   localparam int PROD_W  = htd_pkg::PROD_W;
   localparam int DIFF_W  = htd_pkg::IDX_W + 13;
   localparam logic [htd_pkg::WRAP_SHIFT-1:0] RECIP =
      htd_pkg::WRAP_SHIFT'((2 ** htd_pkg::WRAP_SHIFT + NODE_COUNT - 1) / NODE_COUNT);

   function automatic logic [PROD_W-1:0] wrap_prod(input logic [htd_pkg::IDX_W-1:0] v);
      return PROD_W'(v) * PROD_W'(RECIP);
   endfunction

   function automatic logic [AW-1:0] wrap_rem(input logic [htd_pkg::IDX_W-1:0] v,
                                               input logic [PROD_W-1:0] p);
      logic [htd_pkg::IDX_W-1:0] q;
      logic [DIFF_W-1:0]         diff;
      q    = p[PROD_W-1 -: htd_pkg::IDX_W];
      diff = DIFF_W'(v) - DIFF_W'(q) * DIFF_W'(NODE_COUNT);
      return AW'(diff);
   endfunction

   htd_pkg::state_type state_ff, state_in;
   htd_pkg::op_type    req_op;

   logic req_fire, csr_fire, slot_free;
   logic rd_en, mem_we, emit;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [ENTRY_W-1:0] wr_entry;

   logic [ENTRY_W-1:0] node_mem [NODE_COUNT];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic                     bit_ff;
   logic                     wr_leaf_ff;
   logic [htd_pkg::SYM_W-1:0] wr_sym_ff;
   logic [htd_pkg::IDX_W-1:0] wr_idx_ff, wr_zero_ff, wr_one_ff;
   logic [PROD_W-1:0]        prod_idx_ff, prod_zero_ff, prod_one_ff;

   logic [AW-1:0] walk_ff, next_ff, root_ff;
   logic          finished_ff;
   logic [htd_pkg::IDX_W-1:0] root_src_ff;
   logic [PROD_W-1:0]         root_prod_ff;
   logic                      root_pend_ff;

   logic                      rsp_valid_ff;
   logic [htd_pkg::BYTE_W-1:0] rsp_byte_ff;
   logic                      rsp_last_ff;

   logic                     cur_leaf;
   logic [htd_pkg::SYM_W-1:0] cur_sym;
   logic [AW-1:0]            cur_zero, cur_one;
   logic                     cur_eof;

   assign req_op    = htd_pkg::op_type'(req_tuser);
   assign req_fire  = req_tvalid && req_tready;
   assign csr_fire  = csr_valid && csr_ready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign cur_leaf = rd_data_ff[ENTRY_W-1];
   assign cur_sym  = rd_data_ff[ENTRY_W-2 -: htd_pkg::SYM_W];
   assign cur_zero = rd_data_ff[2*AW-1 -: AW];
   assign cur_one  = rd_data_ff[AW-1:0];
   assign cur_eof  = (cur_sym == htd_pkg::EOF_SYMBOL);

   assign wr_addr  = wrap_rem(wr_idx_ff, prod_idx_ff);
   assign wr_entry = {wr_leaf_ff, wr_sym_ff,
                      wrap_rem(wr_zero_ff, prod_zero_ff), wrap_rem(wr_one_ff, prod_one_ff)};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         htd_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  htd_pkg::OP_WRITE: state_in = htd_pkg::ST_WRITE;
                  htd_pkg::OP_BIT:   state_in = finished_ff ? htd_pkg::ST_IDLE : htd_pkg::ST_CUR;
                  default:           state_in = htd_pkg::ST_IDLE;
               endcase
            end
         end
         htd_pkg::ST_WRITE: state_in = htd_pkg::ST_IDLE;
         htd_pkg::ST_CUR: begin
            if (!cur_leaf) begin
               state_in = htd_pkg::ST_NEXT;
            end else if (slot_free) begin
               state_in = htd_pkg::ST_IDLE;
            end
         end
         htd_pkg::ST_NEXT: begin
            if (!cur_leaf || slot_free) begin
               state_in = htd_pkg::ST_IDLE;
            end
         end
         default: state_in = htd_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = walk_ff;
      mem_we     = 1'b0;
      emit       = 1'b0;
      unique case (state_ff)
         htd_pkg::ST_IDLE: begin
            req_tready = !root_pend_ff;
            csr_ready  = !root_pend_ff;
            rd_en      = req_fire && (req_op == htd_pkg::OP_BIT) && !finished_ff;
         end
         htd_pkg::ST_WRITE: mem_we = 1'b1;
         htd_pkg::ST_CUR: begin
            if (cur_leaf) begin
               emit = slot_free;
            end else begin
               rd_en   = 1'b1;
               rd_addr = bit_ff ? cur_one : cur_zero;
            end
         end
         htd_pkg::ST_NEXT: emit = cur_leaf && slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // node table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_addr];
      end
   end

   // item, root index and result capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         bit_ff       <= req_tdata[0];
         wr_idx_ff    <= req_tdata[10:1];
         wr_leaf_ff   <= req_tdata[11];
         wr_sym_ff    <= req_tdata[20:12];
         wr_zero_ff   <= req_tdata[30:21];
         wr_one_ff    <= req_tdata[40:31];
         prod_idx_ff  <= wrap_prod(req_tdata[10:1]);
         prod_zero_ff <= wrap_prod(req_tdata[30:21]);
         prod_one_ff  <= wrap_prod(req_tdata[40:31]);
      end
      if (state_ff == htd_pkg::ST_CUR) begin
         next_ff <= rd_addr;
      end
      if (csr_fire) begin
         root_src_ff  <= csr_wdata;
         root_prod_ff <= wrap_prod(csr_wdata);
      end
      if (emit) begin
         rsp_byte_ff <= cur_eof ? '0 : cur_sym[htd_pkg::BYTE_W-1:0];
         rsp_last_ff <= cur_eof;
      end
   end

   // walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff      <= '0;
         finished_ff  <= 1'b0;
         root_ff      <= '0;
         root_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         root_pend_ff <= csr_fire;
         if (root_pend_ff) begin
            root_ff <= wrap_rem(root_src_ff, root_prod_ff);
         end
         if (req_fire && (req_op == htd_pkg::OP_RESTART)) begin
            walk_ff     <= root_ff;
            finished_ff <= 1'b0;
         end else if (emit) begin
            walk_ff <= root_ff;
            if (cur_eof) begin
               finished_ff <= 1'b1;
            end
         end else if (state_ff == htd_pkg::ST_NEXT && !cur_leaf) begin
            walk_ff <= next_ff;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: sv/htd_checker.sv
module htd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [htd_pkg::OP_W-1:0]       req_tuser,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [htd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                          rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_eof_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == '0)
      else $error("end mark item with nonzero byte");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp item right after reset");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == htd_pkg::OP_WRITE |=> !req_tready)
      else $error("req ready during table write");

   a_root_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready && !csr_ready)
      else $error("ready while root index settles");

endmodule

bind huffman_tree_decoder_top htd_checker u_htd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: sim/huffman_tree_decoder_top_test.sv
module huffman_tree_decoder_top_test;
   import htd_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int TABLE_SIZE = NODE_COUNT_DEFAULT;
   localparam int MAX_NODES = 32;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic             code_bit;
      logic [IDX_W-1:0] node_index;
      logic             node_is_leaf;
      logic [SYM_W-1:0] node_symbol;
      logic [IDX_W-1:0] zero_child;
      logic [IDX_W-1:0] one_child;
   } req_item;

   typedef struct {
      bit [BYTE_W-1:0] byte_out;
      bit              end_mark;
   } symbol_rec;

   class decode_scoreboard;
      bit             leaf [TABLE_SIZE];
      bit [SYM_W-1:0] sym [TABLE_SIZE];
      bit [IDX_W-1:0] zero_of [TABLE_SIZE];
      bit [IDX_W-1:0] one_of [TABLE_SIZE];
      bit             written [TABLE_SIZE];
      bit [IDX_W-1:0] walk;
      bit [IDX_W-1:0] root;
      bit             finished;
      symbol_rec      symbols_due [$];
      int             failures;

      function new();
         walk = '0;
         root = '0;
         finished = 1'b0;
         failures = 0;
      endfunction

      function int pending();
         return symbols_due.size();
      endfunction

      function void set_root(bit [IDX_W-1:0] r);
         root = r;
      endfunction

      // true when a bit item would only touch table entries already written
      function bit reads_ok(bit b);
         bit [IDX_W-1:0] nxt;
         if (finished)
            return 1'b1;
         if (!written[walk])
            return 1'b0;
         if (leaf[walk])
            return 1'b1;
         nxt = b ? one_of[walk] : zero_of[walk];
         return written[nxt];
      endfunction

      function void emit(bit [SYM_W-1:0] s);
         symbol_rec r;
         if (s == EOF_SYMBOL) begin
            r.byte_out = '0;
            r.end_mark = 1'b1;
            finished = 1'b1;
         end else begin
            r.byte_out = s[BYTE_W-1:0];
            r.end_mark = 1'b0;
         end
         symbols_due.push_back(r);
         walk = root;
      endfunction

      function void note_item(req_item it);
         bit [IDX_W-1:0] nxt;
         case (it.op)
            OP_WRITE: begin
               leaf[it.node_index] = it.node_is_leaf;
               sym[it.node_index] = it.node_symbol;
               zero_of[it.node_index] = it.zero_child;
               one_of[it.node_index] = it.one_child;
               written[it.node_index] = 1'b1;
            end
            OP_RESTART: begin
               walk = root;
               finished = 1'b0;
            end
            OP_BIT: begin
               if (!finished) begin
                  if (leaf[walk]) begin
                     emit(sym[walk]);
                  end else begin
                     nxt = it.code_bit ? one_of[walk] : zero_of[walk];
                     if (leaf[nxt])
                        emit(sym[nxt]);
                     else
                        walk = nxt;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_symbol(logic [BYTE_W-1:0] b, logic last);
         symbol_rec r;
         if (symbols_due.size() == 0) begin
            $error("unexpected rsp item: byte_out %0d end_mark %0b", b, last);
            failures++;
            return;
         end
         r = symbols_due.pop_front();
         if (b !== r.byte_out) begin
            $error("byte_out: expected %0d actual %0d", r.byte_out, b);
            failures++;
         end
         if (last !== r.end_mark) begin
            $error("end_mark: expected %0b actual %0b", r.end_mark, last);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [IDX_W-1:0]      csr_wdata = '0;

   decode_scoreboard sb = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   bit             in_tree [TABLE_SIZE];
   int             t_idx [MAX_NODES];
   bit             t_leaf [MAX_NODES];
   bit [SYM_W-1:0] t_sym [MAX_NODES];
   int             t_zero [MAX_NODES];
   int             t_one [MAX_NODES];

   huffman_tree_decoder_top uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_symbol(rsp_tdata, rsp_tlast);
   end

   function automatic req_item pick(logic [OP_W-1:0] op, logic b);
      req_item it;
      it.op = op;
      it.code_bit = b;
      it.node_index = IDX_W'($urandom);
      it.node_is_leaf = 1'($urandom);
      it.node_symbol = SYM_W'($urandom);
      it.zero_child = IDX_W'($urandom);
      it.one_child = IDX_W'($urandom);
      return it;
   endfunction

   function automatic req_item node_item(logic [IDX_W-1:0] idx, logic is_leaf,
                                         logic [SYM_W-1:0] s, logic [IDX_W-1:0] z,
                                         logic [IDX_W-1:0] o);
      req_item it;
      it = pick(OP_WRITE, 1'($urandom_range(1)));
      it.node_index = idx;
      it.node_is_leaf = is_leaf;
      it.node_symbol = s;
      it.zero_child = z;
      it.one_child = o;
      return it;
   endfunction

   task automatic send_item(req_item it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tdata <= {7'd0, it.one_child, it.zero_child, it.node_symbol, it.node_is_leaf,
                    it.node_index, it.code_bit};
      do @(posedge clock); while (!req_tready);
      sb.note_item(it);
   endtask

   // bit with random payload, flipped or dropped if it would walk into unwritten entries
   task automatic send_bit();
      req_item it;
      it = pick(OP_BIT, 1'($urandom_range(1)));
      if (!sb.reads_ok(it.code_bit))
         it.code_bit = ~it.code_bit;
      if (sb.reads_ok(it.code_bit))
         send_item(it);
   endtask

   task automatic send_noise();
      req_item it;
      case ($urandom_range(2))
         0: begin
            it = pick(OP_WRITE, 1'($urandom_range(1)));
            while (in_tree[it.node_index])
               it.node_index = IDX_W'($urandom);
            send_item(it);
         end
         1: send_item(pick(OP_UNUSED, 1'($urandom_range(1))));
         default: send_bit();
      endcase
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_root(logic [IDX_W-1:0] r);
      csr_valid <= 1'b1;
      csr_wdata <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_root(r);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 46; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 46; end
         default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
      endcase
   endtask

   function automatic int fresh_index();
      int i;
      do i = $urandom_range(TABLE_SIZE - 1); while (in_tree[i]);
      in_tree[i] = 1'b1;
      return i;
   endfunction

   // full binary tree grown by splitting random leaves, then written node by node
   task automatic plant_tree(int root_at, int leaves);
      int n;
      int k;
      logic [IDX_W-1:0] z;
      logic [IDX_W-1:0] o;
      foreach (in_tree[i]) in_tree[i] = 1'b0;
      in_tree[root_at] = 1'b1;
      t_idx[0] = root_at;
      t_leaf[0] = 1'b1;
      n = 1;
      repeat (leaves - 1) begin
         do k = $urandom_range(n - 1); while (!t_leaf[k]);
         t_leaf[k] = 1'b0;
         t_zero[k] = n;
         t_one[k] = n + 1;
         t_idx[n] = fresh_index();
         t_idx[n + 1] = fresh_index();
         t_leaf[n] = 1'b1;
         t_leaf[n + 1] = 1'b1;
         n += 2;
      end
      for (int i = 0; i < n; i++)
         t_sym[i] = SYM_W'($urandom_range(511));
      if ($urandom_range(1)) begin
         do k = $urandom_range(n - 1); while (!t_leaf[k]);
         t_sym[k] = EOF_SYMBOL;
      end
      for (int i = 0; i < n; i++) begin
         z = IDX_W'($urandom);
         o = IDX_W'($urandom);
         if (!t_leaf[i]) begin
            z = IDX_W'(t_idx[t_zero[i]]);
            o = IDX_W'(t_idx[t_one[i]]);
         end
         send_item(node_item(IDX_W'(t_idx[i]), t_leaf[i], t_sym[i], z, o));
         if ($urandom_range(9) == 0)
            send_noise();
      end
   endtask

   initial begin
      int r;
      logic [IDX_W-1:0] root_sel;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // small hand-built tree at root 0: symbol above 256, zero symbol, end of file
      send_item(node_item(10'd0, 1'b0, 9'h1FF, 10'd1023, 10'd1));
      send_item(node_item(10'd1023, 1'b1, 9'h1FF, 10'd1023, 10'd1023));
      send_item(node_item(10'd1, 1'b0, 9'h000, 10'd2, 10'd3));
      send_item(node_item(10'd2, 1'b1, 9'h000, 10'd0, 10'd0));
      send_item(node_item(10'd3, 1'b1, EOF_SYMBOL, 10'd0, 10'd0));
      send_item(pick(OP_BIT, 1'b0));
      send_item(pick(OP_BIT, 1'b1));
      send_item(pick(OP_BIT, 1'b0));
      send_item(pick(OP_BIT, 1'b1));
      send_item(pick(OP_BIT, 1'b1));
      send_item(pick(OP_BIT, 1'b0));
      send_item(pick(OP_UNUSED, 1'b1));
      send_item(pick(OP_RESTART, 1'b0));
      send_item(pick(OP_BIT, 1'b1));
      send_item(pick(OP_RESTART, 1'b1));
      send_item(pick(OP_BIT, 1'b0));

      // root is a leaf
      settle();
      write_root(10'd1023);
      send_item(pick(OP_RESTART, 1'b0));
      send_item(pick(OP_BIT, 1'b0));
      send_item(pick(OP_BIT, 1'b1));

      for (int p = 0; p < 8; p++) begin
         settle();
         set_idling(p % 4);
         root_sel = (p == 0) ? 10'd1023 : (p == 1) ? 10'd0 : 10'($urandom);
         write_root(root_sel);
         plant_tree(int'(root_sel), (p == 2) ? 1 : int'($urandom_range(2, 16)));
         send_item(pick(OP_RESTART, 1'($urandom_range(1))));
         repeat (30) begin
            r = $urandom_range(99);
            if (r < 80)
               send_bit();
            else if (r < 88)
               send_item(pick(OP_RESTART, 1'($urandom_range(1))));
            else
               send_noise();
         end
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("huffman_tree_decoder_top verification clean");
      else
         $display("huffman_tree_decoder_top verification failed");
      $finish;
   end

   initial begin
      #6000000;
      $display("huffman_tree_decoder_top verification failed");
      $finish;
   end

endmodule

FILE: huffman_tree_decoder_top.f
sv/htd_pkg.sv
sv/huffman_tree_decoder_top.sv
sv/htd_checker.sv
sim/huffman_tree_decoder_top_test.sv
